// ===== hw/rtl/lso_pkg.sv =====
// Shared types, constants and the sector decode for the lidar sector occupancy unit.
package lso_pkg;

   // Field widths
   localparam int unsigned DistW      = 16;
   localparam int unsigned ConfW      = 8;
   localparam int unsigned AngleW     = 16;
   localparam int unsigned SectorW    = 6;
   localparam int unsigned CsrIndexW  = 3;
   localparam int unsigned CsrDataW   = 16;

   // Raw robot angle before wrapping: 27000 + offset - sensor spans -38535..92535
   localparam int unsigned RawW = 18;

   localparam logic signed [RawW-1:0] FrameBase  = 18'sd27000;
   localparam logic signed [RawW-1:0] FullTurn   = 18'sd36000;
   localparam logic signed [RawW-1:0] TwoTurns   = 18'sd72000;
   localparam logic signed [RawW-1:0] NegTurn    = -18'sd36000;

   // Sector boundaries, hundredths of a degree
   localparam logic [AngleW-1:0] FrontLeftStart  = 16'd3000;
   localparam logic [AngleW-1:0] RearLeftStart   = 16'd9000;
   localparam logic [AngleW-1:0] RearStart       = 16'd15000;
   localparam logic [AngleW-1:0] RearRightStart  = 16'd21000;
   localparam logic [AngleW-1:0] FrontRightStart = 16'd27000;
   localparam logic [AngleW-1:0] FrontStart      = 16'd33000;

   // Reset value of the far limit
   localparam logic [DistW-1:0] FarLimitReset = 16'hFFFF;

   // Register indexes of the configuration port
   typedef enum logic [CsrIndexW-1:0] {
      CsrConfidenceMin   = 3'd0,
      CsrNearLimit       = 3'd1,
      CsrFarLimit        = 3'd2,
      CsrAngleOffset     = 3'd3,
      CsrBlindLeftStart  = 3'd4,
      CsrBlindLeftEnd    = 3'd5,
      CsrBlindRightStart = 3'd6,
      CsrBlindRightEnd   = 3'd7
   } csr_index_type;

   // Configuration register set
   typedef struct packed {
      logic [ConfW-1:0]  confidence_min;
      logic [DistW-1:0]  near_limit_mm;
      logic [DistW-1:0]  far_limit_mm;
      logic [AngleW-1:0] angle_offset;
      logic [AngleW-1:0] blind_left_start;
      logic [AngleW-1:0] blind_left_end;
      logic [AngleW-1:0] blind_right_start;
      logic [AngleW-1:0] blind_right_end;
   } cfg_type;

   // One-hot sector of a wrapped robot angle; front wraps through zero
   function automatic logic [SectorW-1:0] sector_bit(input logic [AngleW-1:0] angle);
      logic [SectorW-1:0] hit;
      hit = '0;
      if (angle < FrontLeftStart || angle >= FrontStart) begin
         hit[0] = 1'b1;
      end else if (angle < RearLeftStart) begin
         hit[1] = 1'b1;
      end else if (angle < RearStart) begin
         hit[2] = 1'b1;
      end else if (angle < RearRightStart) begin
         hit[3] = 1'b1;
      end else if (angle < FrontRightStart) begin
         hit[4] = 1'b1;
      end else begin
         hit[5] = 1'b1;
      end
      return hit;
   endfunction

endpackage

// ===== hw/rtl/lso_csr.sv =====
// Configuration register file of the lidar sector occupancy unit.
module lso_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [lso_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [lso_pkg::CsrDataW-1:0]   csr_data,
   output lso_pkg::cfg_type               cfg
);

   lso_pkg::cfg_type cfg_ff;
   lso_pkg::cfg_type cfg_in;

   // Decode the write onto the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (lso_pkg::csr_index_type'(csr_index))
            lso_pkg::CsrConfidenceMin:   cfg_in.confidence_min    =
                                            csr_data[lso_pkg::ConfW-1:0];
            lso_pkg::CsrNearLimit:       cfg_in.near_limit_mm     = csr_data;
            lso_pkg::CsrFarLimit:        cfg_in.far_limit_mm      = csr_data;
            lso_pkg::CsrAngleOffset:     cfg_in.angle_offset      = csr_data;
            lso_pkg::CsrBlindLeftStart:  cfg_in.blind_left_start  = csr_data;
            lso_pkg::CsrBlindLeftEnd:    cfg_in.blind_left_end    = csr_data;
            lso_pkg::CsrBlindRightStart: cfg_in.blind_right_start = csr_data;
            lso_pkg::CsrBlindRightEnd:   cfg_in.blind_right_end   = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers; reset loads the documented defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                   <= '0;
         cfg_ff.far_limit_mm      <= lso_pkg::FarLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/lidar_sector_occupancy_unit.sv =====
// Top level: lidar point filter, frame rotation and per-scan sector hit mask.
// A point marked last passes stages 1, 2 and 3 and then the result register before its mask shows on rsp_.
// Throughput: one point per cycle; the three-stage pipe and the result register
// advance together and halt only while a held result is stalled.
// Reset: synchronous, active high; clears the pipe, the hit mask and loads register defaults.
module lidar_sector_occupancy_unit (
   input  logic                           clock,
   input  logic                           reset,
   // point input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lso_pkg::DistW-1:0]      req_distance_mm,
   input  logic [lso_pkg::ConfW-1:0]      req_confidence,
   input  logic [lso_pkg::AngleW-1:0]     req_sensor_angle,
   input  logic                           req_scan_last,
   // scan result
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lso_pkg::SectorW-1:0]    rsp_sector_hits,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lso_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [lso_pkg::CsrDataW-1:0]   csr_data
);

   lso_pkg::cfg_type cfg;

   logic pipe_move;

   // stage 1: input register
   logic                        s1_valid_ff;
   logic [lso_pkg::DistW-1:0]   s1_dist_ff;
   logic [lso_pkg::ConfW-1:0]   s1_conf_ff;
   logic [lso_pkg::AngleW-1:0]  s1_angle_ff;
   logic                        s1_last_ff;

   // stage 2: filter verdict and raw angle
   logic                              s2_valid_ff;
   logic                              s2_keep_ff;
   logic                              s2_keep_in;
   logic signed [lso_pkg::RawW-1:0]   s2_raw_ff;
   logic signed [lso_pkg::RawW-1:0]   s2_raw_in;
   logic                              s2_last_ff;

   // stage 3: wrapped robot angle
   logic                              s3_valid_ff;
   logic                              s3_keep_ff;
   logic [lso_pkg::AngleW-1:0]        s3_angle_ff;
   logic signed [lso_pkg::RawW-1:0]   s3_wrap;
   logic [lso_pkg::AngleW-1:0]        s3_angle_in;
   logic                              s3_last_ff;

   // mask and result
   logic                              blind;
   logic [lso_pkg::SectorW-1:0]       mask_next;
   logic [lso_pkg::SectorW-1:0]       hit_mask_ff;
   logic [lso_pkg::SectorW-1:0]       hit_mask_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [lso_pkg::SectorW-1:0]       rsp_hits_ff;

   lso_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   // Advance the whole pipe unless a held result is stalled
   assign pipe_move = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_move;

   // Stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_move) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_move) begin
         s1_dist_ff  <= req_distance_mm;
         s1_conf_ff  <= req_confidence;
         s1_angle_ff <= req_sensor_angle;
         s1_last_ff  <= req_scan_last;
      end
   end

   // Filter on distance and confidence; form the unwrapped robot angle
   always_comb begin
      s2_keep_in = (s1_dist_ff != '0) && (s1_conf_ff >= cfg.confidence_min) &&
                   (s1_dist_ff >= cfg.near_limit_mm) && (s1_dist_ff <= cfg.far_limit_mm);
      s2_raw_in  = lso_pkg::FrameBase
                 + $signed({2'b00, cfg.angle_offset})
                 - $signed({2'b00, s1_angle_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_move) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_move) begin
         s2_keep_ff <= s2_keep_in;
         s2_raw_ff  <= s2_raw_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Wrap into one turn: at most two turns either way
   always_comb begin
      if (s2_raw_ff < -lso_pkg::FullTurn) begin
         s3_wrap = s2_raw_ff + lso_pkg::TwoTurns;
      end else if (s2_raw_ff < 18'sd0) begin
         s3_wrap = s2_raw_ff + lso_pkg::FullTurn;
      end else if (s2_raw_ff < lso_pkg::FullTurn) begin
         s3_wrap = s2_raw_ff;
      end else if (s2_raw_ff < lso_pkg::TwoTurns) begin
         s3_wrap = s2_raw_ff + lso_pkg::NegTurn;
      end else begin
         s3_wrap = s2_raw_ff - lso_pkg::TwoTurns;
      end
      s3_angle_in = s3_wrap[lso_pkg::AngleW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_move) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_move) begin
         s3_keep_ff  <= s2_keep_ff;
         s3_angle_ff <= s3_angle_in;
         s3_last_ff  <= s2_last_ff;
      end
   end

   // Drop blind-zone points, set the sector bit, emit and clear on the last item
   always_comb begin
      blind = ((s3_angle_ff >= cfg.blind_left_start) &&
               (s3_angle_ff <= cfg.blind_left_end)) ||
              ((s3_angle_ff >= cfg.blind_right_start) &&
               (s3_angle_ff <= cfg.blind_right_end));
      mask_next = hit_mask_ff;
      if (s3_keep_ff && !blind) begin
         mask_next = hit_mask_ff | lso_pkg::sector_bit(s3_angle_ff);
      end
      hit_mask_in  = hit_mask_ff;
      rsp_valid_in = 1'b0;
      if (s3_valid_ff) begin
         rsp_valid_in = s3_last_ff;
         hit_mask_in  = s3_last_ff ? '0 : mask_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_move) begin
         hit_mask_ff  <= hit_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_move) begin
         rsp_hits_ff <= mask_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sector_hits = rsp_hits_ff;

endmodule
